### src/lru_buffer_pool_tags_core_assert.svh
// Assertion macros for the buffer pool tag store.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef LRU_BUFFER_POOL_TAGS_CORE_ASSERT_SVH
`define LRU_BUFFER_POOL_TAGS_CORE_ASSERT_SVH
// Same-cycle implication.
`define LBPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define LBPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### src/lbpt_pkg.sv
// ----------------------------------------------------------------------------
// lbpt_pkg
// Types and codes shared by the buffer pool tag store.
// ----------------------------------------------------------------------------
package lbpt_pkg;

    localparam int TAG_W  = 24;
    localparam int SLOT_W = 6;

    typedef enum logic [1:0] {
        ACT_ACCESS,
        ACT_DIRTY,
        ACT_FREE,
        ACT_FLUSH
    } action_t;

    typedef enum logic [2:0] {
        ST_HIT,
        ST_MISS_FREE,
        ST_MISS_EVICT,
        ST_DIRTY_SET,
        ST_FREED,
        ST_NOT_RES,
        ST_FLUSH_ENTRY,
        ST_FLUSH_EMPTY
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DEC,
        S_WSTK,
        S_WVIC,
        S_EMIT,
        S_FSRCH,
        S_FRD,
        S_FEMIT
    } fsm_t;

endpackage

### src/lbpt_ram.sv
// ----------------------------------------------------------------------------
// lbpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbpt_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem_reg [D];
    logic [W-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/lru_buffer_pool_tags_core.sv
// ----------------------------------------------------------------------------
// lru_buffer_pool_tags_core
// Fully associative tag store with LRU replacement for SLOTS buffer slots.
//
// Input channel (in_valid/in_ready) takes one item: action and block_number.
// Output channel (out_valid/out_ready) gives result items; last marks the
// final result of an item. Access, mark dirty and free give one result;
// flush gives one result per resident slot, most recent first, or a single
// flush-empty result.
// An item is taken only in idle. Every item first scans the tag RAM, one
// slot per cycle. Access, mark dirty and free then decode and emit their
// result, with a free stack or victim tag read step between on an access miss.
// Flush walks recency ranks; each rank searches the slots one per cycle.
// The output register holds a result until taken; a stalled receiver
// stops the sequencer at its next result, and the next item is accepted
// while the final result still waits.
// Reset empties the pool: no slot valid, free stack holds 0..SLOTS-1 with
// slot 0 at the bottom, and the block is ready at once.
// ----------------------------------------------------------------------------
`include "lru_buffer_pool_tags_core_assert.svh"

module lru_buffer_pool_tags_core import lbpt_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [TAG_W-1:0]  block_number,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [SLOT_W-1:0] slot,
    output logic [TAG_W-1:0]  resident_block,
    output logic [TAG_W-1:0]  evicted_block,
    output logic              write_back,
    output logic              last
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // control and sequencing state
    fsm_t              state_reg, state_next;
    action_t           act_reg, act_next;
    logic [TAG_W-1:0]  blk_reg, blk_next;
    logic [SW:0]       idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [SW-1:0]     pidx_reg, pidx_next;
    logic              hit_reg, hit_next;
    logic [SW-1:0]     hslot_reg, hslot_next;
    logic [SW-1:0]     vic_reg, vic_next;
    logic [SW-1:0]     tgt_reg, tgt_next;
    status_t           stat_reg, stat_next;
    logic [SW-1:0]     fa_reg, fa_next;

    // slot state
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [SLOTS-1:0]  dirty_reg, dirty_next;
    logic [SW-1:0]     age_reg [SLOTS];
    logic [SW-1:0]     age_next [SLOTS];
    logic [CW-1:0]     free_count_reg, free_count_next;
    logic [SLOTS-1:0]  stk_wr_reg, stk_wr_next;

    // output register
    logic              oval_reg, oval_next;
    status_t           ostat_reg, ostat_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    logic [TAG_W-1:0]  ores_reg, ores_next;
    logic [TAG_W-1:0]  oevc_reg, oevc_next;
    logic              owb_reg, owb_next;
    logic              olast_reg, olast_next;

    // RAM ports
    logic              tag_we;
    logic [SW-1:0]     tag_raddr;
    logic [TAG_W-1:0]  tag_rdata;
    logic              stk_we;
    logic [SW-1:0]     stk_waddr;
    logic [SW-1:0]     stk_raddr;
    logic [SW-1:0]     stk_rdata;

    // decoded conditions
    logic              out_free;
    logic [SW-1:0]     idx_lo;
    logic              match;
    logic              vmatch;
    logic              scan_done;
    logic              pool_full;
    logic              pool_empty;
    logic              fl_hit;
    logic [CW-1:0]     nvalid;
    logic              fl_last;
    logic [CW-1:0]     fc_m1;
    logic [SW-1:0]     stk_top;

    lbpt_ram #(.W(TAG_W), .D(SLOTS)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tgt_reg),
        .wdata (blk_reg),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    lbpt_ram #(.W(SW), .D(SLOTS)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (tgt_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // shared conditions
    assign out_free   = !oval_reg || out_ready;
    assign idx_lo     = idx_reg[SW-1:0];
    assign match      = pend_reg && valid_reg[pidx_reg] && (tag_rdata == blk_reg);
    assign vmatch     = pend_reg && valid_reg[pidx_reg]
                        && (age_reg[pidx_reg] == SW'(SLOTS - 1));
    assign scan_done  = (idx_reg == (SW+1)'(SLOTS)) && !pend_reg;
    assign pool_full  = (free_count_reg == '0);
    assign pool_empty = (free_count_reg == CW'(SLOTS));
    assign fl_hit     = valid_reg[idx_lo] && (age_reg[idx_lo] == fa_reg);
    assign nvalid     = CW'(SLOTS) - free_count_reg;
    assign fl_last    = ((SW+1)'(fa_reg) + (SW+1)'(1)) == (SW+1)'(nvalid);
    assign fc_m1      = free_count_reg - CW'(1);
    // stack entries never pushed still hold their own index
    assign stk_top    = stk_wr_reg[stk_raddr] ? stk_rdata : stk_raddr;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (act_reg)
                    ACT_ACCESS:
                    begin
                        if (hit_reg)
                        begin
                            state_next = S_EMIT;
                        end
                        else if (!pool_full)
                        begin
                            state_next = S_WSTK;
                        end
                        else
                        begin
                            state_next = S_WVIC;
                        end
                    end
                    ACT_FLUSH:
                    begin
                        state_next = pool_empty ? S_EMIT : S_FSRCH;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_WSTK:  state_next = S_EMIT;
            S_WVIC:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FSRCH:
            begin
                if (fl_hit)
                begin
                    state_next = S_FRD;
                end
            end
            S_FRD:   state_next = S_FEMIT;
            S_FEMIT:
            begin
                if (out_free)
                begin
                    state_next = fl_last ? S_IDLE : S_FSRCH;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state-decoded controls
    always_comb
    begin
        in_ready  = 1'b0;
        tag_raddr = idx_lo;
        tag_we    = 1'b0;
        stk_we    = 1'b0;
        stk_waddr = free_count_reg[SW-1:0];
        stk_raddr = fc_m1[SW-1:0];
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_DEC:   tag_raddr = vic_reg;
            S_WVIC,
            S_FRD,
            S_FEMIT: tag_raddr = tgt_reg;
            S_EMIT:
            begin
                tag_raddr = tgt_reg;
                tag_we    = out_free
                            && (stat_reg == ST_MISS_FREE || stat_reg == ST_MISS_EVICT);
                stk_we    = out_free && (stat_reg == ST_FREED);
            end
            default: tag_raddr = idx_lo;
        endcase
    end

    // datapath next values
    always_comb
    begin
        act_next        = act_reg;
        blk_next        = blk_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        hit_next        = hit_reg;
        hslot_next      = hslot_reg;
        vic_next        = vic_reg;
        tgt_next        = tgt_reg;
        stat_next       = stat_reg;
        fa_next         = fa_reg;
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        age_next        = age_reg;
        free_count_next = free_count_reg;
        stk_wr_next     = stk_wr_reg;
        oval_next       = oval_reg && !out_ready;
        ostat_next      = ostat_reg;
        oslot_next      = oslot_reg;
        ores_next       = ores_reg;
        oevc_next       = oevc_reg;
        owb_next        = owb_reg;
        olast_next      = olast_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action_t'(action);
                    blk_next   = block_number;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    hslot_next = '0;
                    vic_next   = '0;
                    fa_next    = '0;
                end
            end
            // one tag compare per cycle, read data arrives in the cycle after its address
            S_SCAN:
            begin
                if (idx_reg < (SW+1)'(SLOTS))
                begin
                    idx_next  = idx_reg + (SW+1)'(1);
                    pend_next = 1'b1;
                    pidx_next = idx_lo;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (match && !hit_reg)
                begin
                    hit_next   = 1'b1;
                    hslot_next = pidx_reg;
                end
                if (vmatch)
                begin
                    vic_next = pidx_reg;
                end
            end
            S_DEC:
            begin
                tgt_next = hslot_reg;
                idx_next = '0;
                case (act_reg)
                    ACT_ACCESS:
                    begin
                        if (hit_reg)
                        begin
                            stat_next = ST_HIT;
                        end
                        else if (!pool_full)
                        begin
                            stat_next = ST_MISS_FREE;
                        end
                        else
                        begin
                            stat_next = ST_MISS_EVICT;
                            tgt_next  = vic_reg;
                        end
                    end
                    ACT_DIRTY: stat_next = hit_reg ? ST_DIRTY_SET : ST_NOT_RES;
                    ACT_FREE:  stat_next = hit_reg ? ST_FREED : ST_NOT_RES;
                    default:   stat_next = ST_FLUSH_EMPTY;
                endcase
            end
            S_WSTK:  tgt_next = stk_top;
            S_EMIT:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    ostat_next = stat_reg;
                    oslot_next = SLOT_W'(tgt_reg);
                    ores_next  = blk_reg;
                    oevc_next  = '0;
                    owb_next   = 1'b0;
                    olast_next = 1'b1;
                    case (stat_reg)
                        ST_HIT:
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (valid_reg[i] && SW'(i) != tgt_reg
                                    && age_reg[i] < age_reg[tgt_reg])
                                begin
                                    age_next[i] = age_reg[i] + SW'(1);
                                end
                            end
                            age_next[tgt_reg] = '0;
                        end
                        ST_MISS_FREE,
                        ST_MISS_EVICT:
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (valid_reg[i] && SW'(i) != tgt_reg)
                                begin
                                    age_next[i] = age_reg[i] + SW'(1);
                                end
                            end
                            age_next[tgt_reg]   = '0;
                            valid_next[tgt_reg] = 1'b1;
                            dirty_next[tgt_reg] = 1'b0;
                            if (stat_reg == ST_MISS_FREE)
                            begin
                                free_count_next = fc_m1;
                            end
                            else
                            begin
                                oevc_next = tag_rdata;
                                owb_next  = dirty_reg[tgt_reg];
                            end
                        end
                        ST_DIRTY_SET: dirty_next[tgt_reg] = 1'b1;
                        ST_FREED:
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (valid_reg[i] && age_reg[i] > age_reg[tgt_reg])
                                begin
                                    age_next[i] = age_reg[i] - SW'(1);
                                end
                            end
                            valid_next[tgt_reg]                  = 1'b0;
                            dirty_next[tgt_reg]                  = 1'b0;
                            stk_wr_next[free_count_reg[SW-1:0]]  = 1'b1;
                            free_count_next = free_count_reg + CW'(1);
                        end
                        default:
                        begin
                            oslot_next = '0;
                            ores_next  = '0;
                        end
                    endcase
                end
            end
            // flush: find the slot of the current recency rank
            S_FSRCH:
            begin
                if (fl_hit)
                begin
                    tgt_next = idx_lo;
                end
                else
                begin
                    idx_next = idx_reg + (SW+1)'(1);
                end
            end
            S_FEMIT:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    ostat_next = ST_FLUSH_ENTRY;
                    oslot_next = SLOT_W'(tgt_reg);
                    ores_next  = tag_rdata;
                    oevc_next  = '0;
                    owb_next   = 1'b1;
                    olast_next = fl_last;
                    fa_next    = fa_reg + SW'(1);
                    idx_next   = '0;
                end
            end
            default: oval_next = oval_reg && !out_ready;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_reg       <= 1'b0;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            free_count_reg <= CW'(SLOTS);
            stk_wr_reg     <= '0;
            oval_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            valid_reg      <= valid_next;
            dirty_reg      <= dirty_next;
            free_count_reg <= free_count_next;
            stk_wr_reg     <= stk_wr_next;
            oval_reg       <= oval_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        blk_reg   <= blk_next;
        idx_reg   <= idx_next;
        pidx_reg  <= pidx_next;
        hit_reg   <= hit_next;
        hslot_reg <= hslot_next;
        vic_reg   <= vic_next;
        tgt_reg   <= tgt_next;
        stat_reg  <= stat_next;
        fa_reg    <= fa_next;
        age_reg   <= age_next;
        ostat_reg <= ostat_next;
        oslot_reg <= oslot_next;
        ores_reg  <= ores_next;
        oevc_reg  <= oevc_next;
        owb_reg   <= owb_next;
        olast_reg <= olast_next;
    end

    assign out_valid      = oval_reg;
    assign status         = ostat_reg;
    assign slot           = oslot_reg;
    assign resident_block = ores_reg;
    assign evicted_block  = oevc_reg;
    assign write_back     = owb_reg;
    assign last           = olast_reg;

    // checks
    `LBPT_ASSERT_IMP(a_pool_count, 1'b1,
        ($countones(valid_reg) + int'(free_count_reg)) == SLOTS,
        "resident slots and free count disagree")
    `LBPT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "ready stayed high after an item was taken")
    `LBPT_ASSERT_IMP(a_empty_flush_last, out_valid && status == ST_FLUSH_EMPTY,
        last && !write_back, "empty flush result malformed")
    `LBPT_ASSERT_IMP(a_wb_source, out_valid && write_back,
        status == ST_MISS_EVICT || status == ST_FLUSH_ENTRY,
        "write-back flagged on wrong status")

endmodule

### dv/lru_buffer_pool_tags_core_test.sv
// ----------------------------------------------------------------------------
// lru_buffer_pool_tags_core_test
// Self-checking bench for the buffer pool tag store. A directed table walks
// the empty pool, misses into free slots, hits, dirty marks, frees, flushes
// and evictions. Random traffic follows over a small working set. Each
// accepted item is run through a behavioral copy of the tag store, and every
// result item is compared field by field against the expected queue.
// ----------------------------------------------------------------------------
module lru_buffer_pool_tags_core_test import lbpt_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT     = 16;
    localparam int LIMIT     = 400000;
    localparam int NRAND     = 92;
    localparam int DRAIN_CYC = 400;

    typedef struct packed {
        status_t           st;
        logic [SLOT_W-1:0] sl;
        logic [TAG_W-1:0]  res;
        logic [TAG_W-1:0]  evi;
        logic              wb;
        logic              lst;
    } pool_result_t;

    // one directed row; chk set when the expected result is typed in
    typedef struct {
        action_t      act;
        logic [23:0]  blk;
        logic         chk;
        pool_result_t want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        action;
    logic [TAG_W-1:0]  block_number;
    logic              out_valid;
    logic              out_ready;
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  resident_block;
    logic [TAG_W-1:0]  evicted_block;
    logic              write_back;
    logic              last;

    lru_buffer_pool_tags_core #(.SLOTS(NSLOT)) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .block_number   (block_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .slot           (slot),
        .resident_block (resident_block),
        .evicted_block  (evicted_block),
        .write_back     (write_back),
        .last           (last)
    );

    // shadow of the pool state
    logic        pv_valid [NSLOT];
    logic [23:0] pv_tag   [NSLOT];
    logic        pv_dirty [NSLOT];
    int unsigned pv_age   [NSLOT];
    int unsigned pv_stack [NSLOT];
    int unsigned pv_free;

    pool_result_t pending_results[$];
    int           error_count;
    int           cycle_count;
    logic         stall_enable;
    logic         rx_stall_enable;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    function automatic pool_result_t mk_result(status_t st, int unsigned sl,
                                               logic [23:0] res, logic [23:0] evi,
                                               logic wb, logic lst);
        pool_result_t r;
        r.st  = st;
        r.sl  = sl[SLOT_W-1:0];
        r.res = res;
        r.evi = evi;
        r.wb  = wb;
        r.lst = lst;
        return r;
    endfunction

    task automatic pool_reset_shadow();
        for (int i = 0; i < NSLOT; i++)
        begin
            pv_valid[i] = 1'b0;
            pv_tag[i]   = '0;
            pv_dirty[i] = 1'b0;
            pv_age[i]   = 0;
            pv_stack[i] = i;
        end
        pv_free = NSLOT;
    endtask

    // raise recency of slot s; valid slots younger than lim age by one
    task automatic pool_promote(int s, int unsigned lim);
        for (int i = 0; i < NSLOT; i++)
            if (pv_valid[i] && i != s && pv_age[i] < lim)
                pv_age[i]++;
        pv_age[s] = 0;
    endtask

    // apply one item to the shadow and queue its expected results
    task automatic pool_predict(action_t act, logic [23:0] blk);
        int          hit_slot;
        int          victim;
        int unsigned oldest;
        int unsigned a;
        int          n;
        logic [23:0] prev;
        logic        wb;
        int          k;
        hit_slot = -1;
        for (int i = NSLOT - 1; i >= 0; i--)
            if (pv_valid[i] && pv_tag[i] == blk)
                hit_slot = i;
        case (act)
            ACT_ACCESS:
            begin
                if (hit_slot >= 0)
                begin
                    pool_promote(hit_slot, pv_age[hit_slot]);
                    pending_results.push_back(mk_result(ST_HIT, hit_slot, blk, 0, 0, 1));
                end
                else if (pv_free > 0)
                begin
                    pv_free--;
                    n = pv_stack[pv_free];
                    pv_valid[n] = 1'b1;
                    pv_tag[n]   = blk;
                    pv_dirty[n] = 1'b0;
                    pool_promote(n, 32'hFFFF_FFFF);
                    pending_results.push_back(mk_result(ST_MISS_FREE, n, blk, 0, 0, 1));
                end
                else
                begin
                    victim = 0;
                    oldest = 0;
                    for (int i = 0; i < NSLOT; i++)
                        if (pv_valid[i] && (pv_age[i] > oldest || i == 0))
                        begin
                            oldest = pv_age[i];
                            victim = i;
                        end
                    prev = pv_tag[victim];
                    wb   = pv_dirty[victim];
                    pv_tag[victim]   = blk;
                    pv_dirty[victim] = 1'b0;
                    pool_promote(victim, 32'hFFFF_FFFF);
                    pending_results.push_back(mk_result(ST_MISS_EVICT, victim, blk, prev,
                                                        wb, 1));
                end
            end
            ACT_DIRTY, ACT_FREE:
            begin
                if (hit_slot < 0)
                    pending_results.push_back(mk_result(ST_NOT_RES, 0, 0, 0, 0, 1));
                else if (act == ACT_DIRTY)
                begin
                    pv_dirty[hit_slot] = 1'b1;
                    pending_results.push_back(mk_result(ST_DIRTY_SET, hit_slot, blk, 0, 0, 1));
                end
                else
                begin
                    a = pv_age[hit_slot];
                    pv_valid[hit_slot] = 1'b0;
                    pv_dirty[hit_slot] = 1'b0;
                    for (int i = 0; i < NSLOT; i++)
                        if (pv_valid[i] && pv_age[i] > a)
                            pv_age[i]--;
                    pv_stack[pv_free] = hit_slot;
                    pv_free++;
                    pending_results.push_back(mk_result(ST_FREED, hit_slot, blk, 0, 0, 1));
                end
            end
            default:
            begin
                k = 0;
                for (int unsigned r = 0; r < NSLOT; r++)
                    for (int i = 0; i < NSLOT; i++)
                        if (pv_valid[i] && pv_age[i] == r)
                        begin
                            pending_results.push_back(mk_result(ST_FLUSH_ENTRY, i, pv_tag[i],
                                                                0, 1, 0));
                            k++;
                        end
                if (k == 0)
                    pending_results.push_back(mk_result(ST_FLUSH_EMPTY, 0, 0, 0, 0, 1));
                else
                    pending_results[$].lst = 1'b1;
            end
        endcase
    endtask

    // present one item and hold it until accepted
    task automatic send_item(action_t act, logic [23:0] blk);
        while (stall_enable && $urandom_range(99) < 35)
            @(posedge clk);
        in_valid     <= 1'b1;
        action       <= act;
        block_number <= blk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pool_predict(act, blk);
        in_valid <= 1'b0;
        // block is busy after an accept; keeps the drop and the next raise apart
        @(posedge clk);
    endtask

    // receiver: random backpressure, compare against the oldest expectation
    always @(posedge clk)
    begin
        pool_result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item with nothing expected, status %0d", status);
                    error_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (status !== exp_r.st)
                    begin
                        $error("status: expected %0d got %0d", exp_r.st, status);
                        error_count++;
                    end
                    if (slot !== exp_r.sl)
                    begin
                        $error("slot: expected %0d got %0d", exp_r.sl, slot);
                        error_count++;
                    end
                    if (resident_block !== exp_r.res)
                    begin
                        $error("resident_block: expected %0h got %0h", exp_r.res,
                               resident_block);
                        error_count++;
                    end
                    if (evicted_block !== exp_r.evi)
                    begin
                        $error("evicted_block: expected %0h got %0h", exp_r.evi,
                               evicted_block);
                        error_count++;
                    end
                    if (write_back !== exp_r.wb)
                    begin
                        $error("write_back: expected %0b got %0b", exp_r.wb, write_back);
                        error_count++;
                    end
                    if (last !== exp_r.lst)
                    begin
                        $error("last: expected %0b got %0b", exp_r.lst, last);
                        error_count++;
                    end
                end
            end
            out_ready <= !(rx_stall_enable && $urandom_range(99) < 35);
        end
    end

    // timeout
    always @(posedge clk)
    begin
        if (cycle_count > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    stim_row_t   dir_rows[$];
    logic [23:0] work_set[32];

    task automatic add_row(action_t act, logic [23:0] blk, logic chk, pool_result_t w);
        stim_row_t r;
        r.act  = act;
        r.blk  = blk;
        r.chk  = chk;
        r.want = w;
        dir_rows.push_back(r);
    endtask

    initial
    begin
        int unsigned pick;
        action_t     act;
        pool_result_t none;
        none = '0;
        error_count     = 0;
        cycle_count     = 0;
        stall_enable    = 1'b1;
        rx_stall_enable = 1'b1;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_ACCESS;
        block_number = '0;
        out_ready    = 1'b0;
        pool_reset_shadow();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pool, extremes, not-resident codes
        add_row(ACT_FLUSH, 24'h0, 1, mk_result(ST_FLUSH_EMPTY, 0, 0, 0, 0, 1));
        add_row(ACT_DIRTY, 24'hFFFFFF, 1, mk_result(ST_NOT_RES, 0, 0, 0, 0, 1));
        add_row(ACT_FREE, 24'h0, 1, mk_result(ST_NOT_RES, 0, 0, 0, 0, 1));
        add_row(ACT_ACCESS, 24'h0, 1, mk_result(ST_MISS_FREE, 15, 0, 0, 0, 1));
        add_row(ACT_ACCESS, 24'hFFFFFF, 1, mk_result(ST_MISS_FREE, 14, 24'hFFFFFF, 0, 0, 1));
        add_row(ACT_ACCESS, 24'h0, 1, mk_result(ST_HIT, 15, 0, 0, 0, 1));
        add_row(ACT_DIRTY, 24'hFFFFFF, 1, mk_result(ST_DIRTY_SET, 14, 24'hFFFFFF, 0, 0, 1));
        add_row(ACT_FLUSH, 24'h0, 0, none);
        add_row(ACT_FREE, 24'hFFFFFF, 1, mk_result(ST_FREED, 14, 24'hFFFFFF, 0, 0, 1));
        add_row(ACT_ACCESS, 24'h555555, 1, mk_result(ST_MISS_FREE, 14, 24'h555555, 0, 0, 1));
        add_row(ACT_DIRTY, 24'h0, 0, none);
        // fill the pool, then evict the dirty oldest
        for (int i = 0; i < 14; i++)
            add_row(ACT_ACCESS, 24'(24'hAAAA00 + i), 0, none);
        add_row(ACT_ACCESS, 24'h123456, 1, mk_result(ST_MISS_EVICT, 15, 24'h123456, 0, 1, 1));
        add_row(ACT_ACCESS, 24'h654321, 0, none);
        add_row(ACT_FLUSH, 24'h0, 0, none);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].act, dir_rows[i].blk);
            if (dir_rows[i].chk && pending_results[$] !== dir_rows[i].want)
            begin
                $error("directed row %0d: prediction disagrees with table", i);
                error_count++;
            end
        end

        // hold off until everything has drained
        while (pending_results.size() != 0)
            @(posedge clk);

        // random: mostly a small working set so hits, frees and evictions recur
        foreach (work_set[i])
            work_set[i] = 24'($urandom());
        for (int n = 0; n < NRAND; n++)
        begin
            if (n == 40)
            begin
                stall_enable    = 1'b0;
                rx_stall_enable = 1'b0;
            end
            if (n == 70)
            begin
                stall_enable    = 1'b1;
                rx_stall_enable = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55)
                act = ACT_ACCESS;
            else if (pick < 72)
                act = ACT_DIRTY;
            else if (pick < 92)
                act = ACT_FREE;
            else
                act = ACT_FLUSH;
            if ($urandom_range(9) == 0)
                send_item(act, 24'($urandom()));
            else
                send_item(act, work_set[$urandom_range(20)]);
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
